// ----- rtl/lpe_pkg.sv -----
// ----------------------------------------------------------------------------
// lpe_pkg: shared types and constants for the LED pixel bit encoder
// Payload words, config register map, color order codes, lane control.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int RESET_SLOTS_DEF = 40;
  localparam int PIXEL_SLOTS_MAX = 32;
  localparam int NUM_LANES       = 4;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_COLOR_ORDER = 2'd0;
  localparam logic [1:0] REG_BRIGHTNESS  = 2'd1;
  localparam logic [1:0] REG_DUTY_ONE    = 2'd2;
  localparam logic [1:0] REG_DUTY_ZERO   = 2'd3;

  // Reset values
  localparam logic [2:0]  COLOR_ORDER_RST = 3'd0;
  localparam logic [7:0]  BRIGHTNESS_RST  = 8'd255;
  localparam logic [15:0] DUTY_ONE_RST    = 16'd58;
  localparam logic [15:0] DUTY_ZERO_RST   = 16'd29;

  // Stored byte orders; anything else decodes as GRB
  localparam logic [2:0] BYTES_GRB  = 3'd0;
  localparam logic [2:0] BYTES_RGB  = 3'd1;
  localparam logic [2:0] BYTES_BRG  = 3'd2;
  localparam logic [2:0] BYTES_BGR  = 3'd3;
  localparam logic [2:0] BYTES_GRBW = 3'd4;
  localparam logic [2:0] BYTES_RGBW = 3'd5;

  // Item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_EOF   = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } lpe_in_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        last;
  } lpe_out_t;

  typedef struct packed {
    logic [2:0]  color_order;
    logic [7:0]  brightness;
    logic [15:0] duty_one;
    logic [15:0] duty_zero;
  } lpe_cfg_t;

  // Pipeline enables shared by all lanes
  typedef struct packed {
    logic load_prod;
    logic load_scaled;
  } lpe_lane_ctl_t;

endpackage

// ----- rtl/lpe_cfg.sv -----
// ----------------------------------------------------------------------------
// lpe_cfg: APB register file
// Four config registers at byte offsets 0x0, 0x4, 0x8, 0xC; zero wait states.
// ----------------------------------------------------------------------------
module lpe_cfg
  import lpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output lpe_cfg_t          cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_order <= COLOR_ORDER_RST;
      cfg.brightness  <= BRIGHTNESS_RST;
      cfg.duty_one    <= DUTY_ONE_RST;
      cfg.duty_zero   <= DUTY_ZERO_RST;
    end else if (wr) begin
      unique case (idx)
        REG_COLOR_ORDER: cfg.color_order <= pwdata[2:0];
        REG_BRIGHTNESS:  cfg.brightness  <= pwdata[7:0];
        REG_DUTY_ONE:    cfg.duty_one    <= pwdata[15:0];
        REG_DUTY_ZERO:   cfg.duty_zero   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COLOR_ORDER: prdata = {29'd0, cfg.color_order};
      REG_BRIGHTNESS:  prdata = {24'd0, cfg.brightness};
      REG_DUTY_ONE:    prdata = {16'd0, cfg.duty_one};
      REG_DUTY_ZERO:   prdata = {16'd0, cfg.duty_zero};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- rtl/lpe_lane.sv -----
// ----------------------------------------------------------------------------
// lpe_lane: one color channel scaler
// Stage 1 registers value*brightness, stage 2 registers floor(product/255).
// ----------------------------------------------------------------------------
module lpe_lane
  import lpe_pkg::*;
(
  input  logic          clk,
  input  lpe_lane_ctl_t ctl,
  input  logic [7:0]    value,
  input  logic [7:0]    brightness,
  output logic [7:0]    scaled
);

  logic [15:0] prod;
  logic [15:0] sum;

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod <= {8'd0, value} * {8'd0, brightness};
    end
  end

  // x/255 for x <= 255*255: (x + 1 + x/256) / 256, no overflow in 16 bits
  assign sum = prod + 16'd1 + {8'd0, prod[15:8]};

  always_ff @(posedge clk) begin
    if (ctl.load_scaled) begin
      scaled <= sum[15:8];
    end
  end

endmodule

// ----- rtl/lpe_serializer.sv -----
// ----------------------------------------------------------------------------
// lpe_serializer: merge stage and output register
// Packs the lane bytes into one G,R,B,W bit stream and emits a duty word per
// slot, MSB first; end-of-frame items emit the zero-duty trailer.
// ----------------------------------------------------------------------------
module lpe_serializer
  import lpe_pkg::*;
#(
  parameter int RESET_SLOTS = RESET_SLOTS_DEF,
  parameter int SLOT_W      = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      load_op,
  input  logic                      load_four,
  input  logic [NUM_LANES*8-1:0]    load_bits,
  input  logic [15:0]               duty_one,
  input  logic [15:0]               duty_zero,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lpe_out_t                  out_data,
  output logic                      last_now
);

  localparam logic [SLOT_W-1:0] CNT_TRAILER = SLOT_W'(RESET_SLOTS - 1);
  localparam logic [SLOT_W-1:0] CNT_RGBW    = SLOT_W'(PIXEL_SLOTS_MAX - 1);
  localparam logic [SLOT_W-1:0] CNT_RGB     = SLOT_W'(PIXEL_SLOTS_MAX - 9);

  logic [NUM_LANES*8-1:0] bits;
  logic [SLOT_W-1:0]      cnt;
  logic                   op;

  assign last_now = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      cnt       <= (load_op == OP_EOF) ? CNT_TRAILER : (load_four ? CNT_RGBW : CNT_RGB);
    end else if (out_valid && !out_stall) begin
      if (last_now) begin
        out_valid <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bits <= load_bits;
      op   <= load_op;
    end else if (out_valid && !out_stall) begin
      bits <= {bits[NUM_LANES*8-2:0], 1'b0};
    end
  end

  always_comb begin
    if (op == OP_EOF) begin
      out_data.duty = '0;
    end else begin
      out_data.duty = bits[NUM_LANES*8-1] ? duty_one : duty_zero;
    end
    out_data.last = last_now;
  end

endmodule

// ----- rtl/led_pixel_pwm_bit_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// led_pixel_pwm_bit_encoder_unit: LED pixel PWM bit encoder
// Turns pixels into per-bit PWM duty words (G,R,B[,W], MSB first) and ends
// frames with a zero-duty reset trailer.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+-------------------------------------
//   in      | in  | in_valid/in_stall  | lpe_in_t  {op, byte0..byte3}
//   out     | out | out_valid/out_stall| lpe_out_t {duty, last}
//   apb     | in  | psel/penable/pready| color_order, brightness, duty_one/zero
//
// A pixel is 24 duty words (3-byte orders) or 32 (GRBW/RGBW) on the
// output; an end-of-frame word is RESET_SLOTS words. The output register
// sends one word per cycle while out_stall is low. out_valid rises once the input
// word has passed the product (set at the accept edge), scale and output registers.
// Reset (rst, sync) empties the pipeline and loads the register defaults.
// out_stall freezes the output word; the two lane stages keep filling behind
// it, so up to two more input words are taken while a result waits.
//
module led_pixel_pwm_bit_encoder_unit
  import lpe_pkg::*;
#(
  parameter int RESET_SLOTS = RESET_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lpe_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lpe_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // counter holds slots-1; at least wide enough for a 32-slot pixel
  localparam int MAX_SLOTS = (RESET_SLOTS > PIXEL_SLOTS_MAX) ? RESET_SLOTS
                                                               : PIXEL_SLOTS_MAX;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);

  lpe_cfg_t      cfg;
  lpe_lane_ctl_t ctl;

  // pipeline occupancy and sideband
  logic a_valid, a_op, a_four;
  logic b_valid, b_op, b_four;
  logic ser_load, last_now;

  logic [7:0] lane_in  [NUM_LANES];
  logic [7:0] lane_out [NUM_LANES];
  logic       four;

  lpe_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Color order crossbar: lanes are G, R, B, W
  always_comb begin
    lane_in[3] = in_data.byte3;
    four       = 1'b0;
    case (cfg.color_order)
      BYTES_RGB: begin
        lane_in[0] = in_data.byte1;
        lane_in[1] = in_data.byte0;
        lane_in[2] = in_data.byte2;
      end
      BYTES_BRG: begin
        lane_in[0] = in_data.byte2;
        lane_in[1] = in_data.byte1;
        lane_in[2] = in_data.byte0;
      end
      BYTES_BGR: begin
        lane_in[0] = in_data.byte1;
        lane_in[1] = in_data.byte2;
        lane_in[2] = in_data.byte0;
      end
      BYTES_GRBW: begin
        lane_in[0] = in_data.byte0;
        lane_in[1] = in_data.byte1;
        lane_in[2] = in_data.byte2;
        four       = 1'b1;
      end
      BYTES_RGBW: begin
        lane_in[0] = in_data.byte1;
        lane_in[1] = in_data.byte0;
        lane_in[2] = in_data.byte2;
        four       = 1'b1;
      end
      default: begin
        // GRB and the unused codes
        lane_in[0] = in_data.byte0;
        lane_in[1] = in_data.byte1;
        lane_in[2] = in_data.byte2;
      end
    endcase
  end

  // Flow control: each stage moves when the one after it frees up this cycle
  assign ser_load        = b_valid && (!out_valid || (!out_stall && last_now));
  assign ctl.load_scaled = a_valid && (!b_valid || ser_load);
  assign in_stall        = a_valid && !ctl.load_scaled;
  assign ctl.load_prod   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (ctl.load_prod) begin
        a_valid <= 1'b1;
      end else if (ctl.load_scaled) begin
        a_valid <= 1'b0;
      end
      if (ctl.load_scaled) begin
        b_valid <= 1'b1;
      end else if (ser_load) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      a_op   <= in_data.op;
      a_four <= four;
    end
    if (ctl.load_scaled) begin
      b_op   <= a_op;
      b_four <= a_four;
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    lpe_lane u_lane (
      .clk        (clk),
      .ctl        (ctl),
      .value      (lane_in[i]),
      .brightness (cfg.brightness),
      .scaled     (lane_out[i])
    );
  end

  lpe_serializer #(
    .RESET_SLOTS (RESET_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (ser_load),
    .load_op   (b_op),
    .load_four (b_four),
    .load_bits ({lane_out[0], lane_out[1], lane_out[2], lane_out[3]}),
    .duty_one  (cfg.duty_one),
    .duty_zero (cfg.duty_zero),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .last_now  (last_now)
  );

endmodule

// ----- rtl/lpe_checker.sv -----
// ----------------------------------------------------------------------------
// lpe_checker: port-level checks for the LED pixel bit encoder
// Output hold under stall, reset behavior, idle acceptance, item lengths.
// ----------------------------------------------------------------------------
module lpe_checker
  import lpe_pkg::*;
#(
  parameter int RESET_SLOTS = RESET_SLOTS_DEF
) (
  input logic     clk,
  input logic     rst,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input lpe_out_t out_data
);

  // words sent since the last end-of-item
  logic [6:0] slot_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt <= '0;
    end else if (out_valid && !out_stall) begin
      slot_cnt <= out_data.last ? 7'd0 : slot_cnt + 7'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_idle_takes: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_item_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.last |->
      (slot_cnt == 7'd23 || slot_cnt == 7'd31 || slot_cnt == 7'(RESET_SLOTS - 1)))
    else $error("item ended after a wrong number of words");

endmodule

bind led_pixel_pwm_bit_encoder_unit lpe_checker #(
  .RESET_SLOTS (RESET_SLOTS)
) u_lpe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/led_pixel_pwm_bit_encoder_unit_tb.sv -----
// ----------------------------------------------------------------------------
// led_pixel_pwm_bit_encoder_unit_tb: self-checking bench for the LED bit encoder
// Drives pixel and end-of-frame words through the valid/stall input channel.
// Each accepted word is predicted into a queue of duty slots, and every output
// word is checked against the oldest one. The run steps through all color
// orders, brightness and duty extremes, and several idle/stall mixes. Each
// register is read back over APB after it is written.
// ----------------------------------------------------------------------------
module led_pixel_pwm_bit_encoder_unit_tb;
  import lpe_pkg::*;

  localparam int TRAILER_SLOTS = RESET_SLOTS_DEF;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SEGMENTS      = 8;
  localparam int SEG_WORDS     = 19;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  lpe_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  lpe_out_t          out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  led_pixel_pwm_bit_encoder_unit #(
    .RESET_SLOTS(TRAILER_SLOTS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 8 time unit period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  lpe_in_t  pend_words[$];   // words waiting to be driven
  lpe_out_t want_slots[$];   // duty slots the encoder still owes us

  // Shadow copy of the register file, updated at the APB write edge
  logic [2:0]  cur_order  = COLOR_ORDER_RST;
  logic [7:0]  cur_bright = BRIGHTNESS_RST;
  logic [15:0] cur_one    = DUTY_ONE_RST;
  logic [15:0] cur_zero   = DUTY_ZERO_RST;

  int send_gap_pct  = 0;     // chance per cycle the sender holds valid low
  int recv_stall_pct = 0;    // chance per cycle the receiver stalls
  bit in_took       = 1'b0;  // input word accepted at the last rising edge
  int mismatches    = 0;
  int cycle_count   = 0;

  // --------------------------------------------------------------------------
  // Mismatch reporting: one line each, counted
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Slot predictor
  // floor(v * brightness / 255); 255 leaves the byte as is
  // --------------------------------------------------------------------------
  function automatic logic [7:0] dim(input logic [7:0] v);
    logic [15:0] prod;
    prod = {8'd0, v} * {8'd0, cur_bright};
    return 8'(prod / 16'd255);
  endfunction

  // One byte, MSB first, one duty word per bit
  function automatic void expect_byte(input logic [7:0] v, input logic tail);
    lpe_out_t slot;
    for (int k = 7; k >= 0; k--) begin
      slot.duty = v[k] ? cur_one : cur_zero;
      slot.last = tail && (k == 0);
      want_slots.push_back(slot);
    end
  endfunction

  function automatic void predict_word(input lpe_in_t w);
    logic [7:0] g, r, b, wh;
    logic       four;
    lpe_out_t   slot;
    if (w.op == OP_EOF) begin
      // reset trailer: zero duty, last on the final slot, bytes ignored
      for (int k = 0; k < TRAILER_SLOTS; k++) begin
        slot.duty = '0;
        slot.last = (k == TRAILER_SLOTS - 1);
        want_slots.push_back(slot);
      end
    end else begin
      four = 1'b0;
      wh   = '0;
      case (cur_order)
        BYTES_RGB:  begin r = w.byte0; g = w.byte1; b = w.byte2; end
        BYTES_BRG:  begin b = w.byte0; r = w.byte1; g = w.byte2; end
        BYTES_BGR:  begin b = w.byte0; g = w.byte1; r = w.byte2; end
        BYTES_GRBW: begin
          g = w.byte0; r = w.byte1; b = w.byte2; wh = w.byte3; four = 1'b1;
        end
        BYTES_RGBW: begin
          r = w.byte0; g = w.byte1; b = w.byte2; wh = w.byte3; four = 1'b1;
        end
        // GRB, plus the unused codes which fall back to it
        default:    begin g = w.byte0; r = w.byte1; b = w.byte2; end
      endcase
      expect_byte(dim(g), 1'b0);
      expect_byte(dim(r), 1'b0);
      expect_byte(dim(b), !four);
      if (four) begin
        expect_byte(dim(wh), 1'b1);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Rising edge: take accepted input words into the predictor and check
  // accepted output words against the oldest expected slot
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lpe_out_t slot;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_word(in_data);
        in_took = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (want_slots.size() == 0) begin
          flag_mismatch("unexpected word, duty", out_data.duty, -1);
        end else begin
          slot = want_slots.pop_front();
          if (out_data.duty !== slot.duty) begin
            flag_mismatch("duty", out_data.duty, slot.duty);
          end
          if (out_data.last !== slot.last) begin
            flag_mismatch("last", out_data.last, slot.last);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: falling edge. A word stays up until taken; a new one is offered
  // only after the previous one went through. Valid never looks at stall.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (pend_words.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= pend_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_took = 1'b0;
    end
  end

  // Receiver back-pressure, independent of out_valid
  always @(negedge clk) begin
    if (!rst) begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // APB access: setup cycle, then access cycle until pready
  // --------------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input logic [1:0] idx,
                          input logic [DATA_W-1:0] wdata,
                          output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      case (idx)
        REG_COLOR_ORDER: cur_order  = wdata[2:0];
        REG_BRIGHTNESS:  cur_bright = wdata[7:0];
        REG_DUTY_ONE:    cur_one    = wdata[15:0];
        default:         cur_zero   = wdata[15:0];
      endcase
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write, then read back against the shadow copy
  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd, want;
    apb_xfer(1'b1, idx, value, rd);
    apb_xfer(1'b0, idx, '0, rd);
    case (idx)
      REG_COLOR_ORDER: want = DATA_W'(cur_order);
      REG_BRIGHTNESS:  want = DATA_W'(cur_bright);
      REG_DUTY_ONE:    want = DATA_W'(cur_one);
      default:         want = DATA_W'(cur_zero);
    endcase
    if (rd !== want) begin
      flag_mismatch($sformatf("readback reg %0d", idx), rd, want);
    end
  endtask

  // Block until every queued word is taken and every slot has come out;
  // checked at the rising edge, where none of these can be mid-update
  task automatic drain();
    do @(posedge clk);
    while (pend_words.size() != 0 || in_valid || want_slots.size() != 0);
  endtask

  function automatic lpe_in_t mk_pixel(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3);
    lpe_in_t w;
    w.op    = OP_PIXEL;
    w.byte0 = b0;
    w.byte1 = b1;
    w.byte2 = b2;
    w.byte3 = b3;
    return w;
  endfunction

  // Random color byte, biased toward 0x00 and 0xFF
  function automatic logic [7:0] rnd_level();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random 16-bit duty with the extremes well represented
  function automatic logic [15:0] rnd_duty();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    lpe_in_t w;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset config, trailer first, then bit-pattern extremes
    w = '0;
    w.op = OP_EOF;
    w.byte0 = 8'hFF; w.byte1 = 8'hA5; w.byte2 = 8'h5A; w.byte3 = 8'hFF;
    pend_words.push_back(w);
    pend_words.push_back(mk_pixel(8'h00, 8'h00, 8'h00, 8'h00));
    pend_words.push_back(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pend_words.push_back(mk_pixel(8'hAA, 8'h55, 8'hAA, 8'h55));
    drain();

    // Every order code, unused ones included; distinct bytes expose the swap
    for (int k = 0; k < 8; k++) begin
      cfg_write(REG_COLOR_ORDER, k);
      pend_words.push_back(mk_pixel(8'h81, 8'h42, 8'h24, 8'h18));
      drain();
    end

    // Brightness extremes on a four-byte order
    cfg_write(REG_COLOR_ORDER, DATA_W'(BYTES_GRBW));
    cfg_write(REG_BRIGHTNESS, 0);
    pend_words.push_back(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    drain();
    cfg_write(REG_BRIGHTNESS, 1);
    pend_words.push_back(mk_pixel(8'hFF, 8'hFE, 8'h80, 8'h01));
    drain();
    cfg_write(REG_BRIGHTNESS, 128);
    pend_words.push_back(mk_pixel(8'hFF, 8'h7F, 8'h02, 8'hC3));
    drain();

    // Duty extremes, swapped sense, then a trailer under the odd config
    cfg_write(REG_BRIGHTNESS, 255);
    cfg_write(REG_DUTY_ONE, 32'h0000_FFFF);
    cfg_write(REG_DUTY_ZERO, 32'h0000_0000);
    pend_words.push_back(mk_pixel(8'hF0, 8'h0F, 8'h3C, 8'hC3));
    drain();
    cfg_write(REG_DUTY_ONE, 32'h0000_0000);
    cfg_write(REG_DUTY_ZERO, 32'h0000_FFFF);
    pend_words.push_back(mk_pixel(8'hF0, 8'h0F, 8'h3C, 8'hC3));
    pend_words.push_back(w);
    drain();

    // Random segments: fresh config each, cycling through the idle mixes
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      cfg_write(REG_COLOR_ORDER, $urandom_range(7));
      case ($urandom_range(3))
        0:       cfg_write(REG_BRIGHTNESS, 0);
        1:       cfg_write(REG_BRIGHTNESS, 255);
        default: cfg_write(REG_BRIGHTNESS, $urandom_range(255));
      endcase
      cfg_write(REG_DUTY_ONE, DATA_W'(rnd_duty()));
      cfg_write(REG_DUTY_ZERO, DATA_W'(rnd_duty()));

      case (seg % 4)
        0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_gap_pct = 47; recv_stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct = 47; end
        default: begin send_gap_pct = 8;  recv_stall_pct = 8;  end
      endcase

      for (int k = 0; k < SEG_WORDS; k++) begin
        w = mk_pixel(rnd_level(), rnd_level(), rnd_level(), rnd_level());
        if ($urandom_range(99) < 12) begin
          w.op = OP_EOF;
        end
        pend_words.push_back(w);
      end
      drain();
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end

    // Give any stray word a chance to show up, then call it
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lpe_pkg.sv
rtl/lpe_cfg.sv
rtl/lpe_lane.sv
rtl/lpe_serializer.sv
rtl/led_pixel_pwm_bit_encoder_unit.sv
rtl/lpe_checker.sv
tb/led_pixel_pwm_bit_encoder_unit_tb.sv
